>>> design/blpg_pkg.sv
// ----------------------------------------------------------------------------
// blpg_pkg
// Shared types and constants for the line pixel generator.
// ----------------------------------------------------------------------------
package blpg_pkg;

  localparam int COORD_BITS    = 12;
  localparam int DIM_BITS      = 13;
  localparam int ADDR_BITS     = 24;
  localparam int COLOR_BITS    = 32;
  localparam int ERR_BITS      = 15;
  localparam int IN_DATA_BITS  = 80;
  localparam int OUT_DATA_BITS = 80;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  // Operation codes carried in in_tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // One classified command as it travels from the front end to the engine.
  typedef struct packed {
    logic                  is_load;
    logic                  active;
    logic                  steep;
    logic [COORD_BITS-1:0] major_start;
    logic [COORD_BITS-1:0] major_end;
    logic [COORD_BITS-1:0] minor_start;
    logic                  minor_down;
    logic [COORD_BITS-1:0] major_span;
    logic [COORD_BITS-1:0] minor_span;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

endpackage

>>> design/bresenham_line_pixel_generator.sv
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// Bresenham line rasterizer that emits one framebuffer pixel per step word of an active line.
// ----------------------------------------------------------------------------
// A load word (in_tuser = 0) latches two endpoints and a color and produces
// no pixel; each step word (in_tuser = 1) then produces one pixel of the
// line, the final major-axis endpoint excluded, with out_tlast on the last
// one. Steps with no line in progress are dropped. While out_tready is high,
// the block takes one word per cycle, load or step, and puts out one pixel
// per cycle: the pixel engine retires one queued command each cycle, and a
// pixel passes the queue, the address multiply and the output register. A
// four-entry command queue separates input acceptance from the engine, so
// input keeps flowing while a pixel waits at the output until the queue
// fills. The user must write screen width and height through cfg_ only
// while the block is idle (not enforced); width is the address row stride.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator import blpg_pkg::*; #(
  parameter int DEFAULT_WIDTH  = 640,
  parameter int DEFAULT_HEIGHT = 480
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [DIM_BITS-1:0]      cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // start_x, start_y, end_x, end_y, color
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // op
  input  logic                     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // pixel_x, pixel_y, pixel_address, pixel_color
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // write_enable
  output logic                     out_tuser,
  output logic                     out_tlast
);

  logic                  queue_full, push, head_valid, pop;
  cmd_t                  push_cmd, head_cmd;
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic [ADDR_BITS-1:0]  pix_addr;
  logic [COLOR_BITS-1:0] pix_color;

  blpg_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  blpg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  blpg_engine #(
    .DEFAULT_WIDTH  (DEFAULT_WIDTH),
    .DEFAULT_HEIGHT (DEFAULT_HEIGHT)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .head_valid       (head_valid),
    .head_cmd         (head_cmd),
    .pop              (pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_x            (pix_x),
    .out_y            (pix_y),
    .out_address      (pix_addr),
    .out_color        (pix_color),
    .out_write_enable (out_tuser),
    .out_last         (out_tlast)
  );

  assign out_tdata = {pix_color, pix_addr, pix_y, pix_x};

endmodule

>>> design/blpg_front.sv
// ----------------------------------------------------------------------------
// blpg_front
// Accepts input words and classifies them; a load is reduced to major and
// minor axis terms before it is queued.
// ----------------------------------------------------------------------------
module blpg_front import blpg_pkg::*; (
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_BITS-1:0] in_tdata,
  input  logic                    in_tuser,
  input  logic                    queue_full,
  output logic                    push,
  output cmd_t                    cmd
);

  logic [COORD_BITS-1:0] x1, y1, x2, y2;
  logic [COORD_BITS-1:0] dx, dy;
  logic                  steep;
  logic [COORD_BITS-1:0] a1, b1, a2, b2;
  logic                  reorder;
  logic [COORD_BITS-1:0] maj_lo, maj_hi, min_lo, min_hi;

  assign x1 = in_tdata[COORD_BITS-1:0];
  assign y1 = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign x2 = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign y2 = in_tdata[4*COORD_BITS-1:3*COORD_BITS];

  assign in_tready = !queue_full;
  assign push      = in_tvalid && !queue_full;

  always_comb begin
    dx    = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
    dy    = (y2 >= y1) ? (y2 - y1) : (y1 - y2);
    steep = dy > dx;
    a1    = steep ? y1 : x1;
    b1    = steep ? x1 : y1;
    a2    = steep ? y2 : x2;
    b2    = steep ? x2 : y2;
    // Walk the major axis upward.
    reorder = a1 > a2;
    maj_lo  = reorder ? a2 : a1;
    maj_hi  = reorder ? a1 : a2;
    min_lo  = reorder ? b2 : b1;
    min_hi  = reorder ? b1 : b2;

    cmd.is_load     = (in_tuser == OP_LOAD);
    cmd.steep       = steep;
    cmd.major_start = maj_lo;
    cmd.major_end   = maj_hi;
    cmd.minor_start = min_lo;
    cmd.minor_down  = !(min_lo < min_hi);
    cmd.major_span  = maj_hi - maj_lo;
    cmd.minor_span  = steep ? dx : dy;
    cmd.active      = (maj_hi != maj_lo);
    cmd.color       = in_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
  end

endmodule

>>> design/blpg_queue.sv
// ----------------------------------------------------------------------------
// blpg_queue
// Short command queue between the front end and the pixel engine.
// ----------------------------------------------------------------------------
module blpg_queue import blpg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t                 q_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> !pop)
    else $error("pop from an empty queue");

endmodule

>>> design/blpg_engine.sv
// ----------------------------------------------------------------------------
// blpg_engine
// Line state and Bresenham stepper, followed by an address stage and the
// output register.
// ----------------------------------------------------------------------------
module blpg_engine import blpg_pkg::*; #(
  parameter int DEFAULT_WIDTH  = 640,
  parameter int DEFAULT_HEIGHT = 480
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [DIM_BITS-1:0]   cfg_wdata,
  input  logic                  head_valid,
  input  cmd_t                  head_cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [ADDR_BITS-1:0]  out_address,
  output logic [COLOR_BITS-1:0] out_color,
  output logic                  out_write_enable,
  output logic                  out_last
);

  localparam int PROD_BITS = DIM_BITS + COORD_BITS;

  logic [DIM_BITS-1:0] width_r, height_r;

  // Line state.
  logic                  active_r, active_nxt;
  logic                  steep_r, steep_nxt;
  logic [COORD_BITS-1:0] major_r, major_nxt;
  logic [COORD_BITS-1:0] major_end_r, major_end_nxt;
  logic [COORD_BITS-1:0] minor_r, minor_nxt;
  logic                  down_r, down_nxt;
  logic [DIM_BITS-1:0]   dmin2_r, dmin2_nxt;
  logic [DIM_BITS-1:0]   back2_r, back2_nxt;
  logic [ERR_BITS-1:0]   err_r, err_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;

  // Address stage and output register.
  logic                  s1_valid_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic [ADDR_BITS-1:0]  s1_prod_r;
  logic [COLOR_BITS-1:0] s1_color_r;
  logic                  s1_we_r, s1_last_r;
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [ADDR_BITS-1:0]  out_addr_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic                  out_we_r, out_last_r;

  logic                  s1_ready, s2_ready, fire;
  logic [COORD_BITS-1:0] px, py;
  logic                  is_last, in_screen;
  logic [PROD_BITS-1:0]  prod_full;
  logic [ERR_BITS-1:0]   err_sub, err_alt;
  logic [COORD_BITS-1:0] span_gap;

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  // A step without an active line is dropped, so only real pixels wait on
  // the address stage.
  assign pop  = head_valid && (head_cmd.is_load || !active_r || s1_ready);
  assign fire = pop && !head_cmd.is_load && active_r;

  assign px        = steep_r ? minor_r : major_r;
  assign py        = steep_r ? major_r : minor_r;
  assign is_last   = (major_r + 1'b1) == major_end_r;
  assign in_screen = ({1'b0, px} < width_r) && ({1'b0, py} < height_r);
  assign prod_full = {{DIM_BITS{1'b0}}, py} * {{COORD_BITS{1'b0}}, width_r};

  // Both outcomes of the error update are formed in parallel; the sign of
  // the first one selects.
  assign err_sub  = err_r - {{(ERR_BITS-DIM_BITS){1'b0}}, dmin2_r};
  assign err_alt  = err_r + {{(ERR_BITS-DIM_BITS){1'b0}}, back2_r};
  assign span_gap = head_cmd.major_span - head_cmd.minor_span;

  always_comb begin
    active_nxt    = active_r;
    steep_nxt     = steep_r;
    major_nxt     = major_r;
    major_end_nxt = major_end_r;
    minor_nxt     = minor_r;
    down_nxt      = down_r;
    dmin2_nxt     = dmin2_r;
    back2_nxt     = back2_r;
    err_nxt       = err_r;
    color_nxt     = color_r;
    if (pop && head_cmd.is_load) begin
      active_nxt    = head_cmd.active;
      steep_nxt     = head_cmd.steep;
      major_nxt     = head_cmd.major_start;
      major_end_nxt = head_cmd.major_end;
      minor_nxt     = head_cmd.minor_start;
      down_nxt      = head_cmd.minor_down;
      dmin2_nxt     = {head_cmd.minor_span, 1'b0};
      back2_nxt     = {span_gap, 1'b0};
      err_nxt       = {{(ERR_BITS-COORD_BITS){1'b0}}, head_cmd.major_span};
      color_nxt     = head_cmd.color;
    end else if (fire) begin
      major_nxt = major_r + 1'b1;
      if (err_sub[ERR_BITS-1]) begin
        minor_nxt = down_r ? minor_r - 1'b1 : minor_r + 1'b1;
        err_nxt   = err_alt;
      end else begin
        err_nxt = err_sub;
      end
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_BITS'(DEFAULT_WIDTH);
      height_r <= DIM_BITS'(DEFAULT_HEIGHT);
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) begin
        width_r <= cfg_wdata;
      end
      if (cfg_index == REG_HEIGHT) begin
        height_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (s1_ready) begin
        s1_valid_r <= fire;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    steep_r     <= steep_nxt;
    major_r     <= major_nxt;
    major_end_r <= major_end_nxt;
    minor_r     <= minor_nxt;
    down_r      <= down_nxt;
    dmin2_r     <= dmin2_nxt;
    back2_r     <= back2_nxt;
    err_r       <= err_nxt;
    color_r     <= color_nxt;
    if (s1_ready) begin
      s1_x_r     <= px;
      s1_y_r     <= py;
      s1_prod_r  <= prod_full[ADDR_BITS-1:0];
      s1_color_r <= color_r;
      s1_we_r    <= in_screen;
      s1_last_r  <= is_last;
    end
    if (s2_ready) begin
      out_x_r     <= s1_x_r;
      out_y_r     <= s1_y_r;
      out_addr_r  <= s1_prod_r + {{(ADDR_BITS-COORD_BITS){1'b0}}, s1_x_r};
      out_color_r <= s1_color_r;
      out_we_r    <= s1_we_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_address      = out_addr_r;
  assign out_color        = out_color_r;
  assign out_write_enable = out_we_r;
  assign out_last         = out_last_r;

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_last) |=> !active_r)
    else $error("line still active after its last pixel");

  a_error_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !err_r[ERR_BITS-1])
    else $error("error term negative on an active line");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_ready) |=> s1_valid_r)
    else $error("address stage lost a pixel under stall");

endmodule
